// File: hdl/spp_pkg.sv
package spp_pkg;

  // default sizes
  localparam int unsigned MAX_DIM_DEF         = 4096;
  localparam int unsigned SINE_INDEX_BITS_DEF = 10;

  // fixed widths of the datapath
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned LEVEL_W = 8;

  // level arithmetic constants
  localparam logic [LEVEL_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam int unsigned        LEVEL_BIAS   = 127;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_TERMS = 10;
  localparam logic [63:0] Q15_MAX = 64'd32767;

  // one sine sample: sign and Q0.15 magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_t;

  // sin(pi/2 * k / 2^ib) rounded to Q0.15 by an integer Taylor series,
  // used at elaboration only to fill the quarter-wave table
  function automatic logic [MAG_W-1:0] sine_q15(input int unsigned k, input int unsigned ib);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] q;
    longint      acc;
    a    = (HALF_PI_Q30 * 64'(k)) >> ib;
    a2   = (a * a) >> 30;
    term = a;
    acc  = longint'(a);
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = (64'(acc) + 64'd16384) >> 15;
    if (q > Q15_MAX) begin
      q = Q15_MAX;
    end
    return q[MAG_W-1:0];
  endfunction

endpackage

// File: hdl/spp_phase.sv
module spp_phase import spp_pkg::*; #(
  parameter int unsigned COORD_W = 12
) (
  input  logic               clk,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  input  logic [PHASE_W-1:0] step,
  output logic [PHASE_W-1:0] phase_x,
  output logic [PHASE_W-1:0] phase_y
);

  logic [COORD_W+PHASE_W-1:0] prod_x;
  logic [COORD_W+PHASE_W-1:0] prod_y;

  // coordinate times step, kept modulo one turn
  assign prod_x = {{PHASE_W{1'b0}}, x} * {{COORD_W{1'b0}}, step};
  assign prod_y = {{PHASE_W{1'b0}}, y} * {{COORD_W{1'b0}}, step};

  always_ff @(posedge clk) begin
    phase_x <= prod_x[PHASE_W-1:0];
    phase_y <= prod_y[PHASE_W-1:0];
  end

endmodule

// File: hdl/spp_sine_rom.sv
module spp_sine_rom import spp_pkg::*; #(
  parameter int unsigned SINE_INDEX_BITS = 10
) (
  input  logic               clk,
  input  logic [PHASE_W-1:0] phase,
  output sine_t              sine
);

  localparam int unsigned IB = SINE_INDEX_BITS;
  localparam int unsigned N  = 1 << IB;

  typedef logic [MAG_W-1:0] tab_t [0:N];

  function automatic tab_t build_tab();
    tab_t t;
    for (int unsigned k = 0; k <= N; k++) begin
      t[k] = sine_q15(k, IB);
    end
    return t;
  endfunction

  localparam tab_t QUARTER_TAB = build_tab();
  localparam logic [IB:0] TOP_ADDR = {1'b1, {IB{1'b0}}};

  logic [IB-1:0] idx;
  logic [IB:0]   addr;

  // odd quadrants run the quarter wave backwards
  assign idx  = phase[PHASE_W-3 -: IB];
  assign addr = phase[PHASE_W-2] ? (TOP_ADDR - {1'b0, idx}) : {1'b0, idx};

  // registered table read, lower half-turn negative
  always_ff @(posedge clk) begin
    sine.mag <= QUARTER_TAB[addr];
    sine.neg <= phase[PHASE_W-1];
  end

endmodule

// File: hdl/spp_level.sv
module spp_level import spp_pkg::*; (
  input  logic               clk,
  input  sine_t              sa,
  input  sine_t              sb,
  output logic [LEVEL_W-1:0] grey
);

  localparam int unsigned SUM_W = MAG_W + 3;
  localparam int unsigned V_W   = SUM_W + 7;

  logic signed [SUM_W-1:0] va;
  logic signed [SUM_W-1:0] vb;
  logic signed [SUM_W-1:0] sum;
  logic signed [V_W-1:0]   sum_ext;
  logic signed [V_W-1:0]   level;

  // signed samples
  assign va = sa.neg ? -$signed({3'b000, sa.mag}) : $signed({3'b000, sa.mag});
  assign vb = sb.neg ? -$signed({3'b000, sb.mag}) : $signed({3'b000, sb.mag});
  assign sum = va + vb;
  assign sum_ext = V_W'(sum);

  // 127*2^16 + 127*(sa + sb), never negative
  assign level = (V_W'(LEVEL_BIAS) <<< 16) + (sum_ext <<< 7) - sum_ext;

  always_ff @(posedge clk) begin
    grey <= level[16 +: LEVEL_W];
  end

endmodule

// File: hdl/sine_plasma_pixel_generator_top.sv
// Sine plasma pixel generator
//
// Request channel: pixel_x and pixel_y are taken at a rising edge where
// start is high and busy is low. busy is high only while rst is held, so
// a new pixel can be requested on every clock.
// Result channel: result_valid is high for one cycle with grey_level and
// alpha_level; alpha_level is always 255. The receiver cannot stall, so
// results must be taken as they come.
// Configuration: phase_step is written through cfg_valid/cfg_data; cfg_ready
// is always high. Write it only while no pixel is in flight.
// Pipeline: a request passes the input register, the phase multiply, the
// quarter-wave table read and the level sum; result_valid rises with the
// result of the level sum.
// Throughput: one pixel per clock while rst is low; the phase multiply stage
// holds two 12x32 multiplies and the table read stage two registered reads.
// Reset: synchronous; clears phase_step to zero and drops every request in
// flight.
module sine_plasma_pixel_generator_top import spp_pkg::*; #(
  parameter  int unsigned MAX_DIM         = MAX_DIM_DEF,
  parameter  int unsigned SINE_INDEX_BITS = SINE_INDEX_BITS_DEF,
  localparam int unsigned COORD_W         = $clog2(MAX_DIM)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [PHASE_W-1:0] cfg_data,
  output logic               result_valid,
  output logic [LEVEL_W-1:0] grey_level,
  output logic [LEVEL_W-1:0] alpha_level
);

  logic [PHASE_W-1:0] phase_step;
  logic [COORD_W-1:0] x_in;
  logic [COORD_W-1:0] y_in;
  logic               v_in;
  logic               v_phase;
  logic               v_sine;
  logic [PHASE_W-1:0] phase_x;
  logic [PHASE_W-1:0] phase_y;
  sine_t              sine_x;
  sine_t              sine_y;
  logic               accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // phase step register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (cfg_valid && cfg_ready) begin
      phase_step <= cfg_data;
    end
  end

  // request input register
  always_ff @(posedge clk) begin
    if (accept) begin
      x_in <= pixel_x;
      y_in <= pixel_y;
    end
  end

  // valid chain alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in         <= 1'b0;
      v_phase      <= 1'b0;
      v_sine       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v_in         <= accept;
      v_phase      <= v_in;
      v_sine       <= v_phase;
      result_valid <= v_sine;
    end
  end

  spp_phase #(
    .COORD_W (COORD_W)
  ) u_phase (
    .clk     (clk),
    .x       (x_in),
    .y       (y_in),
    .step    (phase_step),
    .phase_x (phase_x),
    .phase_y (phase_y)
  );

  spp_sine_rom #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_sine_x (
    .clk   (clk),
    .phase (phase_x),
    .sine  (sine_x)
  );

  spp_sine_rom #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_sine_y (
    .clk   (clk),
    .phase (phase_y),
    .sine  (sine_y)
  );

  spp_level u_level (
    .clk  (clk),
    .sa   (sine_x),
    .sb   (sine_y),
    .grey (grey_level)
  );

  assign alpha_level = ALPHA_OPAQUE;

  // every request gives a result at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 result_valid)
    else $error("request lost in the pipeline");

  // no result without a matching earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, 4))
    else $error("result without a request");

  // table saturation keeps the level below 254
  a_grey_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (grey_level <= 8'd253))
    else $error("grey level out of range");

endmodule
